// ===== rtl/mtl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared types and constants of the timer list.
// ----------------------------------------------------------------------------
package mtl_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TAG_WIDTH_DEF = 8;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    typedef struct packed {
        action_t     action;
        logic [30:0] elapsed;
        logic [7:0]  timer_tag;
        logic [30:0] period;
        logic        repeat_req;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] fired_tag;
        status_t    status;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// ===== rtl/mtl_req_if.sv =====
// ----------------------------------------------------------------------------
// mtl_req_if
// Request channel: valid, ready and one request.
// ----------------------------------------------------------------------------
interface mtl_req_if
    import mtl_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mtl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mtl_rsp_if
// Result channel: valid, ready and one result.
// ----------------------------------------------------------------------------
interface mtl_rsp_if
    import mtl_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mtl_cell.sv =====
// ----------------------------------------------------------------------------
// mtl_cell
// One list slot: holds an entry, takes its upper neighbor on shift, or a
// new entry on load.
// ----------------------------------------------------------------------------
module mtl_cell
    import mtl_pkg::*;
#(
    parameter int EW = 71
) (
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [EW-1:0] nbr,
    input  logic [EW-1:0] ld,
    output logic [EW-1:0] q
);

    logic [EW-1:0] entry_reg;
    logic [EW-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = ld;
        end
        else if (ctl.shift)
        begin
            entry_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== rtl/multi_timer_list.sv =====
// ----------------------------------------------------------------------------
// multi_timer_list
// Ordered list of timers held in a chain of cells; tick and remove walk
// the list through the head cell.
// ----------------------------------------------------------------------------
// Add and clear go from idle to the status state, which issues the status
//   result; tick and remove first walk each stored entry through the head
//   cell, one head cell step per cycle while the result side does not stall.
//   New requests are taken only in idle, after the status result is issued,
//   even while it waits. Reset: count and control cleared; entries undefined.
module multi_timer_list
    import mtl_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mtl_req_if.sink    req,
    mtl_rsp_if.source  rsp
);

    localparam int EW = TAG_WIDTH + 31 + 31 + 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_STAT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      c_reg, c_next;
    logic [CW-1:0]      w_reg, w_next;
    action_t            act_reg, act_next;
    logic [30:0]        elapsed_reg, elapsed_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic               found_reg, found_next;
    status_t            stat_reg, stat_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic [EW-1:0]      q [SLOTS];
    cell_ctl_t          ctl [SLOTS];
    logic [EW-1:0]      ld_entry;
    logic [IW-1:0]      ld_ptr;
    logic               ld_en;
    logic               shift_en;
    logic [CW-1:0]      ins_sum;

    logic [TAG_WIDTH-1:0] h_tag;
    logic [30:0]        h_period;
    logic [30:0]        h_rem;
    logic               h_rep;
    logic [31:0]        left;
    logic               fire;
    logic               keep;
    logic               slot_free;
    logic               step;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            logic [EW-1:0] nbr;
            if (g == SLOTS - 1)
            begin : g_top
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = q[g+1];
            end
            assign ctl[g].shift = shift_en;
            assign ctl[g].load  = ld_en && (ld_ptr == IW'(g));
            mtl_cell #(.EW(EW)) u_cell (
                .clk (clk),
                .ctl (ctl[g]),
                .nbr (nbr),
                .ld  (ld_entry),
                .q   (q[g])
            );
        end
    endgenerate

    assign {h_tag, h_period, h_rem, h_rep} = q[0];
    assign left      = {1'b0, h_rem} - {1'b0, elapsed_reg};
    assign fire      = (act_reg == ACT_TICK) && (left[31] || left == 32'd0);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign step      = (state_reg == S_WALK) && slot_free;
    assign ins_sum   = c_reg - CW'(1) + w_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        c_next         = c_reg;
        w_next         = w_reg;
        act_next       = act_reg;
        elapsed_next   = elapsed_reg;
        tag_next       = tag_reg;
        found_next     = found_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        shift_en       = 1'b0;
        ld_en          = 1'b0;
        ld_ptr         = ins_sum[IW-1:0];
        ld_entry       = q[0];
        keep           = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next     = req.data.action;
                    elapsed_next = req.data.elapsed;
                    tag_next     = TAG_WIDTH'(req.data.timer_tag);
                    found_next   = 1'b0;
                    stat_next    = ST_OK;
                    c_next       = count_reg;
                    w_next       = '0;
                    state_next   = S_STAT;
                    case (req.data.action)
                        ACT_TICK, ACT_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_WALK;
                            end
                            else if (req.data.action == ACT_REMOVE)
                            begin
                                stat_next = ST_NOT_FOUND;
                            end
                        end
                        ACT_ADD:
                        begin
                            if (count_reg >= CW'(SLOTS))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                ld_en      = 1'b1;
                                ld_ptr     = count_reg[IW-1:0];
                                ld_entry   = {TAG_WIDTH'(req.data.timer_tag),
                                              req.data.period, req.data.period,
                                              req.data.repeat_req};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (act_reg == ACT_TICK)
                begin
                    keep     = !fire || h_rep;
                    ld_entry = {h_tag, h_period, fire ? h_period : left[30:0], h_rep};
                end
                else if (!found_reg && h_tag == tag_reg)
                begin
                    keep       = 1'b0;
                end
                if (step)
                begin
                    shift_en = 1'b1;
                    ld_en    = keep;
                    if (!keep && act_reg == ACT_REMOVE)
                    begin
                        found_next = 1'b1;
                    end
                    if (fire)
                    begin
                        out_valid_next     = 1'b1;
                        out_next.kind      = KIND_FIRE;
                        out_next.fired_tag = 8'(h_tag);
                        out_next.status    = ST_OK;
                        out_next.last      = 1'b0;
                    end
                    c_next = c_reg - CW'(1);
                    w_next = w_reg + CW'(keep);
                    if (c_reg == CW'(1))
                    begin
                        count_next = w_reg + CW'(keep);
                        state_next = S_STAT;
                        if (act_reg == ACT_REMOVE && !found_reg && keep)
                        begin
                            stat_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_STAT:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.kind      = KIND_STATUS;
                    out_next.fired_tag = '0;
                    out_next.status    = stat_reg;
                    out_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            c_reg         <= '0;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            c_reg         <= c_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        elapsed_reg <= elapsed_next;
        tag_reg     <= tag_next;
        found_reg   <= found_next;
        stat_reg    <= stat_next;
        out_reg     <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("list count above capacity");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> c_reg != '0)
        else $error("walk with no entries left");

    a_walk_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> (c_reg + w_reg) <= CW'(SLOTS))
        else $error("walk spans past the last cell");

    a_fire_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_next && !out_next.last && state_reg == S_WALK
            |-> act_reg == ACT_TICK)
        else $error("fire result outside a tick");

endmodule

// ===== verif/tb_multi_timer_list.sv =====
// ----------------------------------------------------------------------------
// tb_multi_timer_list
// Drives add, remove, clear and tick requests into the timer list, predicts
// fire and status results from a local copy of the list, and compares every
// result in order under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_multi_timer_list;
    import mtl_pkg::*;

    localparam int NSLOT     = SLOTS_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LONG = 400;

    logic clk;
    logic rst_n;

    mtl_req_if req_ch ();
    mtl_rsp_if rsp_ch ();

    multi_timer_list uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    logic [7:0]         tl_tag[NSLOT];
    logic [30:0]        tl_period[NSLOT];
    logic signed [32:0] tl_left[NSLOT];
    logic               tl_rep[NSLOT];
    int                 tl_count;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  err_count;
    int  idle_cycles;
    int  fire_seen;
    int  req_done;

    function automatic rsp_t mk_rsp(logic k, logic [7:0] t, status_t s, logic l);
        rsp_t r;
        r.kind      = k;
        r.fired_tag = t;
        r.status    = s;
        r.last      = l;
        return r;
    endfunction

    task automatic predict_list(input req_t r);
        status_t st;
        int      w;
        int      hit;
        logic signed [32:0] left;
        bit      keep;
        st = ST_OK;
        case (r.action)
            ACT_TICK:
            begin
                w = 0;
                for (int i = 0; i < tl_count; i++)
                begin
                    left = tl_left[i] - $signed({2'b00, r.elapsed});
                    keep = 1;
                    if (left <= 0)
                    begin
                        expected_rsps.push_back(mk_rsp(KIND_FIRE, tl_tag[i], ST_OK, 1'b0));
                        if (tl_rep[i])
                            left = $signed({2'b00, tl_period[i]});
                        else
                            keep = 0;
                    end
                    if (keep)
                    begin
                        tl_tag[w]    = tl_tag[i];
                        tl_period[w] = tl_period[i];
                        tl_rep[w]    = tl_rep[i];
                        tl_left[w]   = left;
                        w++;
                    end
                end
                tl_count = w;
            end
            ACT_ADD:
            begin
                if (tl_count >= NSLOT)
                    st = ST_FULL;
                else
                begin
                    tl_tag[tl_count]    = r.timer_tag;
                    tl_period[tl_count] = r.period;
                    tl_left[tl_count]   = $signed({2'b00, r.period});
                    tl_rep[tl_count]    = r.repeat_req;
                    tl_count++;
                end
            end
            ACT_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < tl_count; i++)
                    if (hit < 0 && tl_tag[i] == r.timer_tag)
                        hit = i;
                if (hit < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    for (int i = hit; i + 1 < tl_count; i++)
                    begin
                        tl_tag[i]    = tl_tag[i+1];
                        tl_period[i] = tl_period[i+1];
                        tl_left[i]   = tl_left[i+1];
                        tl_rep[i]    = tl_rep[i+1];
                    end
                    tl_count--;
                end
            end
            default: tl_count = 0;
        endcase
        expected_rsps.push_back(mk_rsp(KIND_STATUS, 8'd0, st, 1'b1));
    endtask

    function automatic req_t mk_req(action_t a, logic [30:0] el, logic [7:0] t,
                                    logic [30:0] p, logic rp);
        req_t r;
        r.action     = a;
        r.elapsed    = el;
        r.timer_tag  = t;
        r.period     = p;
        r.repeat_req = rp;
        return r;
    endfunction

    function automatic logic [30:0] rnd_span();
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic req_t rnd_req();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return mk_req(ACT_ADD, 31'($urandom), 8'($urandom_range(0, 23)),
                          rnd_span(), 1'($urandom));
        else if (sel < 75)
            return mk_req(ACT_TICK, rnd_span(), 8'($urandom), 31'($urandom), 1'($urandom));
        else if (sel < 95)
            return mk_req(ACT_REMOVE, 31'($urandom), 8'($urandom_range(0, 23)),
                          31'($urandom), 1'($urandom));
        else
            return mk_req(ACT_CLEAR, 31'($urandom), 8'($urandom), 31'($urandom),
                          1'($urandom));
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (NSLOT + 4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid && req_ch.ready)
                req_done <= req_done + 1;
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_ch.data  <= pending_reqs[0];
                predict_list(pending_reqs.pop_front());
                req_ch.valid <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result kind=%0d tag=%0d", rsp_ch.data.kind,
                       rsp_ch.data.fired_tag);
                err_count++;
            end
            else
            begin
                if (rsp_ch.data.kind !== expected_rsps[0].kind)
                begin
                    $error("kind: expected %0d, got %0d", expected_rsps[0].kind,
                           rsp_ch.data.kind);
                    err_count++;
                end
                if (rsp_ch.data.fired_tag !== expected_rsps[0].fired_tag)
                begin
                    $error("fired_tag: expected %0d, got %0d", expected_rsps[0].fired_tag,
                           rsp_ch.data.fired_tag);
                    err_count++;
                end
                if (rsp_ch.data.status !== expected_rsps[0].status)
                begin
                    $error("status: expected %0d, got %0d", expected_rsps[0].status,
                           rsp_ch.data.status);
                    err_count++;
                end
                if (rsp_ch.data.last !== expected_rsps[0].last)
                begin
                    $error("last: expected %0d, got %0d", expected_rsps[0].last,
                           rsp_ch.data.last);
                    err_count++;
                end
                if (expected_rsps[0].kind == KIND_FIRE)
                    fire_seen++;
                void'(expected_rsps.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb_multi_timer_list: done, errors");
            $finish;
        end
    end

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        err_count      = 0;
        idle_cycles    = 0;
        fire_seen      = 0;
        req_done       = 0;
        tl_count       = 0;
        rst_n          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        pending_reqs.push_back(mk_req(ACT_TICK, 31'h7FFF_FFFF, 8'hFF, 31'h7FFF_FFFF, 1'b1));
        pending_reqs.push_back(mk_req(ACT_REMOVE, 31'd0, 8'd5, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_ADD, 31'h7FFF_FFFF, 8'h00, 31'd0, 1'b1));
        pending_reqs.push_back(mk_req(ACT_ADD, 31'd0, 8'hFF, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_ADD, 31'd0, 8'hAA, 31'h7FFF_FFFF, 1'b1));
        pending_reqs.push_back(mk_req(ACT_ADD, 31'd0, 8'h55, 31'd3, 1'b0));
        pending_reqs.push_back(mk_req(ACT_TICK, 31'd0, 8'd0, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_TICK, 31'd3, 8'd0, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_TICK, 31'h7FFF_FFFF, 8'd0, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_REMOVE, 31'd0, 8'hAA, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_REMOVE, 31'd0, 8'hAA, 31'd0, 1'b0));
        for (int i = 0; i < NSLOT + 1; i++)
            pending_reqs.push_back(mk_req(ACT_ADD, 31'd0, 8'(i), 31'(i % 3), 1'(i)));
        pending_reqs.push_back(mk_req(ACT_TICK, 31'd1, 8'd0, 31'd0, 1'b0));
        pending_reqs.push_back(mk_req(ACT_CLEAR, 31'h7FFF_FFFF, 8'hFF, 31'h7FFF_FFFF, 1'b1));
        pending_reqs.push_back(mk_req(ACT_TICK, 31'd5, 8'd0, 31'd0, 1'b0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 54 : 33) : 0;
            recv_stall_pct = (ph == 2) ? 54 : ((ph == 3) ? 33 : 0);
            for (int i = 0; i < 16; i++)
                pending_reqs.push_back(mk_req(ACT_ADD, 31'd0, 8'($urandom_range(0, 23)),
                                              31'($urandom_range(0, 3)), 1'b1));
            for (int i = 0; i < 40; i++)
                pending_reqs.push_back(rnd_req());
            if (ph == 0)
                hold_cycles = HOLD_LONG;
            wait_drained();
        end

        $display("tb_multi_timer_list: %0d requests, %0d timer fires checked",
                 req_done, fire_seen);
        $display("tb_multi_timer_list: across 4 idle/stall phases and one long stall");
        if (err_count == 0)
            $display("tb_multi_timer_list: done, clean");
        else
            $display("tb_multi_timer_list: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mtl_pkg.sv
rtl/mtl_req_if.sv
rtl/mtl_rsp_if.sv
rtl/mtl_cell.sv
rtl/multi_timer_list.sv
verif/tb_multi_timer_list.sv
